// File: hw/rtl/imp_pkg.sv
// imp_pkg: shared types, codes and constants for immediate-mode primitive assembly
// used by every module under hw/rtl
package imp_pkg;

  // command codes
  localparam logic [2:0] CMD_BEGIN    = 3'd0;
  localparam logic [2:0] CMD_TEXCOORD = 3'd1;
  localparam logic [2:0] CMD_RGBA     = 3'd2;
  localparam logic [2:0] CMD_RGB      = 3'd3;
  localparam logic [2:0] CMD_VERTEX   = 3'd4;

  // primitive modes
  localparam logic [1:0] MODE_TRIANGLES = 2'd0;
  localparam logic [1:0] MODE_QUADS     = 2'd1;

  // float 1.0 bit pattern
  localparam logic [31:0] ONE_BITS = 32'h3F80_0000;

  // vertex store and queue sizing
  localparam int StoreDepth = 4;
  localparam int SlotW      = $clog2(StoreDepth);
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // last store slot of a primitive and last output step of a run
  localparam logic [SlotW-1:0] TRI_LAST_SLOT  = SlotW'(2);
  localparam logic [SlotW-1:0] QUAD_LAST_SLOT = SlotW'(3);
  localparam logic [2:0]       TRI_LAST_STEP  = 3'd2;
  localparam logic [2:0]       QUAD_LAST_STEP = 3'd5;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_TRI,
    EMIT_QUAD
  } emit_t;

  // one assembled vertex with its attributes
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] alpha;
    logic [31:0] u;
    logic [31:0] v;
  } vtx_data_t;

  // item passed from front to back
  typedef struct packed {
    logic [SlotW-1:0] slot;
    emit_t            kind;
    vtx_data_t        data;
  } vtx_rec_t;

  // emitted vertex
  typedef struct packed {
    vtx_data_t data;
    logic      last;
  } vtx_out_t;

  // store slot for step k of a run
  function automatic logic [SlotW-1:0] run_slot(emit_t kind, logic [2:0] k);
    logic [SlotW-1:0] s;
    s = '0;
    if (kind == EMIT_QUAD) begin
      case (k)
        3'd0:    s = SlotW'(0);
        3'd1:    s = SlotW'(1);
        3'd2:    s = SlotW'(3);
        3'd3:    s = SlotW'(1);
        3'd4:    s = SlotW'(2);
        3'd5:    s = SlotW'(3);
        default: s = '0;
      endcase
    end else begin
      s = k[SlotW-1:0];
    end
    return s;
  endfunction

endpackage

// File: hw/rtl/imp_if.sv
// imp channel interfaces: command input channel and vertex output channel
// depends on nothing; valid/ready handshake with source and sink modports
interface imp_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [1:0]  mode;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [31:0] word_c;
  logic [31:0] word_d;

  modport source (output valid, command, mode, word_a, word_b, word_c, word_d,
                  input ready);
  modport sink (input valid, command, mode, word_a, word_b, word_c, word_d,
                output ready);
endinterface

interface imp_vtx_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [31:0] out_red;
  logic [31:0] out_green;
  logic [31:0] out_blue;
  logic [31:0] out_alpha;
  logic [31:0] out_u;
  logic [31:0] out_v;
  logic        last_of_run;

  modport source (output valid, out_x, out_y, out_z, out_red, out_green, out_blue,
                  out_alpha, out_u, out_v, last_of_run, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_red, out_green, out_blue,
                out_alpha, out_u, out_v, last_of_run, output ready);
endinterface

// File: hw/rtl/immediate_mode_primitive_assembly.sv
// Immediate-mode primitive assembly: takes begin, texcoord, color and vertex
// commands and emits triangle-list vertices. Commands are accepted one per cycle
// as long as the four-entry record queue has room; begin and attribute commands
// never reach the queue. Each vertex is written into the vertex store when
// the back pops it; a completed triangle is then emitted as 3 vertices, a quad
// as 6 (order 0,1,3,1,2,3), paced by the single output register. Vertices in
// a mode other than triangles or quads are dropped. Attribute words pass through
// as raw bits. Depends on imp_pkg, imp_if, imp_front, imp_queue and imp_back.
module immediate_mode_primitive_assembly (
  input  logic       clk,
  input  logic       rst,
  imp_cmd_if.sink    in_ch,
  imp_vtx_if.source  out_ch
);

  logic              push_valid, push_ready;
  imp_pkg::vtx_rec_t push_rec;
  logic              pop_valid, pop_ready;
  imp_pkg::vtx_rec_t pop_rec;
  imp_pkg::vtx_out_t out_item;

  imp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .command    (in_ch.command),
    .mode       (in_ch.mode),
    .word_a     (in_ch.word_a),
    .word_b     (in_ch.word_b),
    .word_c     (in_ch.word_c),
    .word_d     (in_ch.word_d),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  imp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  imp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_rec   (pop_rec),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  // output payload
  assign out_ch.out_x       = out_item.data.x;
  assign out_ch.out_y       = out_item.data.y;
  assign out_ch.out_z       = out_item.data.z;
  assign out_ch.out_red     = out_item.data.red;
  assign out_ch.out_green   = out_item.data.green;
  assign out_ch.out_blue    = out_item.data.blue;
  assign out_ch.out_alpha   = out_item.data.alpha;
  assign out_ch.out_u       = out_item.data.u;
  assign out_ch.out_v       = out_item.data.v;
  assign out_ch.last_of_run = out_item.last;

endmodule

// File: hw/rtl/imp_front.sv
// imp_front: decodes commands, latches current color and texcoord, tags vertices
// depends on imp_pkg; pushes vertex records toward the back through imp_queue
module imp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          command,
  input  logic [1:0]          mode,
  input  logic [31:0]         word_a,
  input  logic [31:0]         word_b,
  input  logic [31:0]         word_c,
  input  logic [31:0]         word_d,
  output logic                push_valid,
  input  logic                push_ready,
  output imp_pkg::vtx_rec_t   push_rec
);

  logic [31:0] cur_u, cur_v, cur_red, cur_green, cur_blue, cur_alpha;
  logic [1:0]  prim_mode;
  logic [imp_pkg::SlotW-1:0] count;
  logic        accept;
  logic        mode_ok;
  imp_pkg::emit_t kind;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign mode_ok  = (prim_mode == imp_pkg::MODE_TRIANGLES) ||
                    (prim_mode == imp_pkg::MODE_QUADS);

  // decide whether this vertex completes a primitive
  always_comb begin
    kind = imp_pkg::EMIT_NONE;
    if (prim_mode == imp_pkg::MODE_QUADS && count == imp_pkg::QUAD_LAST_SLOT) begin
      kind = imp_pkg::EMIT_QUAD;
    end else if (prim_mode == imp_pkg::MODE_TRIANGLES &&
                 count == imp_pkg::TRI_LAST_SLOT) begin
      kind = imp_pkg::EMIT_TRI;
    end
  end

  // record for the back
  assign push_valid = accept && command == imp_pkg::CMD_VERTEX && mode_ok;
  always_comb begin
    push_rec.slot       = count;
    push_rec.kind       = kind;
    push_rec.data.x     = word_a;
    push_rec.data.y     = word_b;
    push_rec.data.z     = word_c;
    push_rec.data.red   = cur_red;
    push_rec.data.green = cur_green;
    push_rec.data.blue  = cur_blue;
    push_rec.data.alpha = cur_alpha;
    push_rec.data.u     = cur_u;
    push_rec.data.v     = cur_v;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      prim_mode <= imp_pkg::MODE_TRIANGLES;
      count     <= '0;
    end else if (accept) begin
      case (command)
        imp_pkg::CMD_BEGIN: begin
          prim_mode <= mode;
          count     <= '0;
        end
        imp_pkg::CMD_VERTEX: begin
          if (!mode_ok || kind != imp_pkg::EMIT_NONE) begin
            count <= '0;
          end else begin
            count <= count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // current attributes
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_u     <= '0;
      cur_v     <= '0;
      cur_red   <= '0;
      cur_green <= '0;
      cur_blue  <= '0;
      cur_alpha <= '0;
    end else if (accept) begin
      case (command)
        imp_pkg::CMD_TEXCOORD: begin
          cur_u <= word_a;
          cur_v <= word_b;
        end
        imp_pkg::CMD_RGBA: begin
          cur_red   <= word_a;
          cur_green <= word_b;
          cur_blue  <= word_c;
          cur_alpha <= word_d;
        end
        imp_pkg::CMD_RGB: begin
          cur_red   <= word_a;
          cur_green <= word_b;
          cur_blue  <= word_c;
          cur_alpha <= imp_pkg::ONE_BITS;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/imp_queue.sv
// imp_queue: small fifo of vertex records between front and back
// depends on imp_pkg for the record type and depth
module imp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  imp_pkg::vtx_rec_t push_rec,
  output logic              pop_valid,
  input  logic              pop_ready,
  output imp_pkg::vtx_rec_t pop_rec
);

  imp_pkg::vtx_rec_t        entries [imp_pkg::QueueDepth];
  logic [imp_pkg::QPtrW-1:0] wr_ptr, rd_ptr;
  logic [imp_pkg::QCntW-1:0] fill;
  logic push, pop;

  assign push_ready = fill != imp_pkg::QCntW'(imp_pkg::QueueDepth);
  assign pop_valid  = fill != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_rec    = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: ;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_rec;
  end

endmodule

// File: hw/rtl/imp_back.sv
// imp_back: holds the four-entry vertex store and plays out triangle runs
// depends on imp_pkg; feeds a registered output stage
module imp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  imp_pkg::vtx_rec_t pop_rec,
  output logic              out_valid,
  input  logic              out_ready,
  output imp_pkg::vtx_out_t out_item
);

  imp_pkg::vtx_data_t store [imp_pkg::StoreDepth];
  logic           busy;
  imp_pkg::emit_t run_kind;
  logic [2:0]     step;
  logic           out_load;
  logic           last_step;
  logic           pop;

  assign pop_ready = !busy;
  assign pop       = pop_valid && pop_ready;
  assign out_load  = !out_valid || out_ready;
  assign last_step = (run_kind == imp_pkg::EMIT_QUAD) ? (step == imp_pkg::QUAD_LAST_STEP)
                                                      : (step == imp_pkg::TRI_LAST_STEP);

  // vertex store
  always_ff @(posedge clk) begin
    if (pop) store[pop_rec.slot] <= pop_rec.data;
  end

  // run sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      run_kind  <= imp_pkg::EMIT_NONE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (busy && out_load) begin
        out_valid <= 1'b1;
        step      <= step + 1'b1;
        if (last_step) busy <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop && pop_rec.kind != imp_pkg::EMIT_NONE) begin
        busy     <= 1'b1;
        run_kind <= pop_rec.kind;
        step     <= '0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (busy && out_load) begin
      out_item.data <= store[imp_pkg::run_slot(run_kind, step)];
      out_item.last <= last_step;
    end
  end

endmodule

// File: tb/immediate_mode_primitive_assembly_tb.sv
// testbench for immediate_mode_primitive_assembly: command stream in, triangle-list vertices out
// depends on imp_pkg, imp_if and the block; a built-in vertex predictor checks every output
// directed commands first, then random primitives, with bursty input and a stalling receiver
module immediate_mode_primitive_assembly_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // codes the block has no name for
  localparam logic [1:0] MODE_OTHER     = 2'd2;
  localparam logic [1:0] MODE_SPARE     = 2'd3;
  localparam logic [2:0] CMD_UNKNOWN_LO = imp_pkg::CMD_VERTEX + 3'd1;
  localparam logic [2:0] CMD_UNKNOWN_HI = '1;

  // store order of the two triangles of a quad, two bits per step
  localparam logic [11:0] QUAD_ORDER = {2'd3, 2'd2, 2'd1, 2'd3, 2'd1, 2'd0};

  localparam int RANDOM_ITEMS = 320;

  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  mode;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } cmd_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  imp_cmd_if cmd_ch ();
  imp_vtx_if vtx_ch ();

  immediate_mode_primitive_assembly dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (cmd_ch),
    .out_ch (vtx_ch)
  );

  always #4 clk = ~clk;

  cmd_item_t          commands_pending[$];
  imp_pkg::vtx_out_t  vertices_due[$];

  int errors          = 0;
  int vertices_seen   = 0;
  int commands_taken  = 0;
  int planned_items   = 0;
  bit cmd_offered     = 1'b0;
  bit cmd_taken       = 1'b0;
  bit hold_off        = 1'b0;

  // predictor state, matching the block after reset
  imp_pkg::vtx_data_t attrs_now  = '0;
  logic [1:0]         prim_mode  = imp_pkg::MODE_TRIANGLES;
  int                 filled     = 0;
  imp_pkg::vtx_data_t corners[4];

  // update the latched attributes and the vertex store, queue emitted vertices
  task automatic assemble_command(input cmd_item_t it);
    imp_pkg::vtx_out_t emitted;
    int                run_len;
    int                pick;
    case (it.command)
      imp_pkg::CMD_BEGIN: begin
        prim_mode = it.mode;
        filled = 0;
      end
      imp_pkg::CMD_TEXCOORD: begin
        attrs_now.u = it.a;
        attrs_now.v = it.b;
      end
      imp_pkg::CMD_RGBA: begin
        attrs_now.red   = it.a;
        attrs_now.green = it.b;
        attrs_now.blue  = it.c;
        attrs_now.alpha = it.d;
      end
      imp_pkg::CMD_RGB: begin
        attrs_now.red   = it.a;
        attrs_now.green = it.b;
        attrs_now.blue  = it.c;
        attrs_now.alpha = imp_pkg::ONE_BITS;
      end
      imp_pkg::CMD_VERTEX: begin
        if (prim_mode != imp_pkg::MODE_TRIANGLES && prim_mode != imp_pkg::MODE_QUADS) begin
          filled = 0;
        end else begin
          corners[filled] = attrs_now;
          corners[filled].x = it.a;
          corners[filled].y = it.b;
          corners[filled].z = it.c;
          filled++;
          run_len = 0;
          if (prim_mode == imp_pkg::MODE_QUADS && filled == 4) run_len = 6;
          if (prim_mode == imp_pkg::MODE_TRIANGLES && filled == 3) run_len = 3;
          for (int k = 0; k < run_len; k++) begin
            pick = (prim_mode == imp_pkg::MODE_QUADS) ? int'(QUAD_ORDER[2*k +: 2]) : k;
            emitted.data = corners[pick];
            emitted.last = (k == run_len - 1);
            vertices_due.push_back(emitted);
          end
          if (run_len != 0) filled = 0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return imp_pkg::ONE_BITS;
      default: return $urandom;
    endcase
  endfunction

  // mode is only meaningful for begin; elsewhere it is noise
  task automatic queue_command(input logic [2:0] cmd, input logic [1:0] md,
                               input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c, input logic [31:0] d);
    cmd_item_t it;
    it.command = cmd;
    it.mode    = (cmd == imp_pkg::CMD_BEGIN) ? md : 2'($urandom_range(0, 3));
    it.a = a;
    it.b = b;
    it.c = c;
    it.d = d;
    commands_pending.push_back(it);
    if (cmd <= imp_pkg::CMD_VERTEX) planned_items++;
  endtask

  task automatic queue_attribute();
    logic [2:0] cmd;
    case ($urandom_range(0, 2))
      0:       cmd = imp_pkg::CMD_TEXCOORD;
      1:       cmd = imp_pkg::CMD_RGBA;
      default: cmd = imp_pkg::CMD_RGB;
    endcase
    queue_command(cmd, imp_pkg::MODE_TRIANGLES, pick_word(), pick_word(), pick_word(),
                  pick_word());
  endtask

  task automatic queue_vertex();
    queue_command(imp_pkg::CMD_VERTEX, imp_pkg::MODE_TRIANGLES, pick_word(), pick_word(),
                  pick_word(), pick_word());
  endtask

  // directed: reset attributes, extremes, every command, mode changes mid-primitive
  task automatic build_directed();
    // triangle from reset state, attributes still zero
    queue_command(imp_pkg::CMD_VERTEX, imp_pkg::MODE_QUADS, '0, '0, '0, '1);
    queue_command(imp_pkg::CMD_VERTEX, imp_pkg::MODE_QUADS, '1, '1, '1, '0);
    queue_command(imp_pkg::CMD_VERTEX, imp_pkg::MODE_QUADS, 32'h8000_0000, 32'h7F80_0000,
                  imp_pkg::ONE_BITS, '1);
    // quad with attributes changing between corners
    queue_command(imp_pkg::CMD_TEXCOORD, imp_pkg::MODE_TRIANGLES, '1, '0, '1, '1);
    queue_command(imp_pkg::CMD_RGBA, imp_pkg::MODE_TRIANGLES, '1, '0, '1, '0);
    queue_command(imp_pkg::CMD_BEGIN, imp_pkg::MODE_QUADS, '0, '0, '0, '0);
    queue_vertex();
    queue_command(imp_pkg::CMD_RGB, imp_pkg::MODE_TRIANGLES, '0, '1, '0, '0);
    queue_vertex();
    queue_command(imp_pkg::CMD_TEXCOORD, imp_pkg::MODE_TRIANGLES, '0, '1, '0, '0);
    queue_vertex();
    queue_vertex();
    // partial quad dropped by a new begin, unknown command inside a triangle
    queue_vertex();
    queue_vertex();
    queue_command(imp_pkg::CMD_BEGIN, imp_pkg::MODE_TRIANGLES, '1, '1, '1, '1);
    queue_vertex();
    queue_vertex();
    queue_command(CMD_UNKNOWN_LO, imp_pkg::MODE_QUADS, '1, '1, '1, '1);
    queue_vertex();
    // modes that drop vertices
    queue_command(imp_pkg::CMD_BEGIN, MODE_OTHER, '0, '0, '0, '0);
    queue_vertex();
    queue_command(imp_pkg::CMD_BEGIN, MODE_SPARE, '0, '0, '0, '0);
    queue_vertex();
    queue_command(CMD_UNKNOWN_LO + 3'd1, imp_pkg::MODE_QUADS, '0, '0, '0, '0);
    queue_command(CMD_UNKNOWN_HI, imp_pkg::MODE_QUADS, '1, '0, '1, '0);
  endtask

  // random: mostly well-formed primitives, some truncated ones, some noise
  task automatic build_random();
    int         kind;
    int         need;
    int         verts;
    logic [1:0] md;
    planned_items = 0;
    while (planned_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        md   = (kind < 4) ? imp_pkg::MODE_QUADS : imp_pkg::MODE_TRIANGLES;
        need = (md == imp_pkg::MODE_QUADS) ? 4 : 3;
        queue_command(imp_pkg::CMD_BEGIN, md, pick_word(), pick_word(), pick_word(),
                      pick_word());
        repeat ($urandom_range(1, 4)) begin
          verts = ($urandom_range(0, 9) == 0) ? $urandom_range(1, need - 1) : need;
          repeat (verts) begin
            if ($urandom_range(0, 2) == 0) queue_attribute();
            queue_vertex();
          end
        end
      end else if (kind == 8) begin
        md = ($urandom_range(0, 1) == 0) ? MODE_OTHER : MODE_SPARE;
        queue_command(imp_pkg::CMD_BEGIN, md, pick_word(), pick_word(), pick_word(),
                      pick_word());
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 1) == 0) queue_attribute();
          queue_vertex();
        end
      end else begin
        repeat ($urandom_range(2, 6))
          queue_command(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), pick_word(),
                        pick_word(), pick_word(), pick_word());
      end
    end
  endtask

  // command driver: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    cmd_item_t it;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_offered || cmd_taken) begin
      cmd_offered = 1'b0;
      cmd_taken   = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        cmd_ch.valid <= 1'b0;
      end else if (commands_pending.size() > 0) begin
        it = commands_pending.pop_front();
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= it.command;
        cmd_ch.mode    <= it.mode;
        cmd_ch.word_a  <= it.a;
        cmd_ch.word_b  <= it.b;
        cmd_ch.word_c  <= it.c;
        cmd_ch.word_d  <= it.d;
        cmd_offered = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
        end
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // command accepted: run the predictor
  always @(posedge clk) begin
    cmd_item_t it;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      it.command = cmd_ch.command;
      it.mode    = cmd_ch.mode;
      it.a = cmd_ch.word_a;
      it.b = cmd_ch.word_b;
      it.c = cmd_ch.word_c;
      it.d = cmd_ch.word_d;
      assemble_command(it);
      cmd_taken = 1'b1;
      commands_taken++;
    end
  end

  // vertex receiver: stall style is redrawn at random from four patterns
  rx_style_t rx_style  = RX_STREAM;
  int        rx_left   = 0;
  int        rx_cycles = 0;

  always @(negedge clk) begin
    bit go;
    if (rst) begin
      vtx_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style = rx_style_t'($urandom_range(0, 3));
        rx_left  = $urandom_range(8, 60);
      end
      rx_left--;
      rx_cycles++;
      case (rx_style)
        RX_STREAM: go = 1'b1;
        RX_COIN:   go = 1'($urandom_range(0, 1));
        RX_SPARSE: go = ($urandom_range(0, 3) == 0);
        default:   go = (rx_cycles % 3 != 0);
      endcase
      vtx_ch.ready <= go && !hold_off;
    end
  end

  // long receiver hold-off so the record queue fills and the input stalls
  initial begin
    for (int k = 0; k < 2; k++) begin
      wait (commands_taken >= 60 + k * 150);
      @(posedge clk);
      hold_off = 1'b1;
      repeat (90) @(posedge clk);
      hold_off = 1'b0;
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("vertex %0d %s: expected %h got %h", vertices_seen, what, want, got);
    end
  endtask

  // vertex monitor: compare with the oldest prediction
  always @(posedge clk) begin
    imp_pkg::vtx_out_t want;
    if (!rst && vtx_ch.valid && vtx_ch.ready) begin
      if (vertices_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("vertex %0d arrived with none expected", vertices_seen);
      end else begin
        want = vertices_due.pop_front();
        check_field("x", want.data.x, vtx_ch.out_x);
        check_field("y", want.data.y, vtx_ch.out_y);
        check_field("z", want.data.z, vtx_ch.out_z);
        check_field("red", want.data.red, vtx_ch.out_red);
        check_field("green", want.data.green, vtx_ch.out_green);
        check_field("blue", want.data.blue, vtx_ch.out_blue);
        check_field("alpha", want.data.alpha, vtx_ch.out_alpha);
        check_field("u", want.data.u, vtx_ch.out_u);
        check_field("v", want.data.v, vtx_ch.out_v);
        check_field("last_of_run", 32'(want.last), 32'(vtx_ch.last_of_run));
      end
      vertices_seen++;
    end
  end

  // main sequence
  initial begin
    cmd_ch.valid   = 1'b0;
    cmd_ch.command = imp_pkg::CMD_BEGIN;
    cmd_ch.mode    = imp_pkg::MODE_TRIANGLES;
    cmd_ch.word_a  = '0;
    cmd_ch.word_b  = '0;
    cmd_ch.word_c  = '0;
    cmd_ch.word_d  = '0;
    vtx_ch.ready   = 1'b0;
    build_directed();
    build_random();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (commands_pending.size() == 0 && !cmd_offered && vertices_due.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && vertices_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
